[src/assert_macros.svh]
// Assertion helpers used by the checker file fic_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");

// Check prop at every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

[src/fic_pkg.sv]
`timescale 1ns / 1ps
package fic_pkg;

   localparam int NEEDLE_BYTES  = 64;
   localparam int POSITION_BITS = 16;
   localparam int ADDR_BITS     = (NEEDLE_BYTES > 1) ? $clog2(NEEDLE_BYTES) : 1;
   localparam int LEN_BITS      = $clog2(NEEDLE_BYTES + 1);
   localparam int OUT_POS_BITS  = 16;

   localparam logic [7:0] SEPARATOR  = 8'h2C;
   localparam logic       CMD_NEEDLE = 1'b0;
   localparam logic       CMD_LIST   = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] byte_value;
      logic       no_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [OUT_POS_BITS-1:0] position;
      logic                    needle_overflow;
      logic                    count_saturated;
   } rsp_type;

   // One item as it moves from the RAM read into the field compare.
   typedef struct packed {
      logic                clear;
      logic                is_list;
      logic                has_byte;
      logic                is_sep;
      logic                last;
      logic [7:0]          byte_value;
      logic [LEN_BITS-1:0] idx;
      logic [LEN_BITS-1:0] len;
      logic                too_long;
   } stage_type;

endpackage

[src/fic_ram.sv]
`timescale 1ns / 1ps
module fic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/fic_field.sv]
`timescale 1ns / 1ps
module fic_field (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  fic_pkg::stage_type entry,
   input  logic [7:0]         rd_data,
   output fic_pkg::rsp_type   result
);
   import fic_pkg::*;

   typedef struct packed {
      logic [POSITION_BITS-1:0] number;
      logic [POSITION_BITS-1:0] found;
      logic                     flag;
   } count_type;

   localparam logic [POSITION_BITS-1:0] FIELD_MAX = '1;

   logic      differs_ff, differs_in;
   count_type count_ff, count_in;

   count_type                count_a, count_b;
   logic                     plain, sep, byte_differs, differs_after;
   logic [LEN_BITS-1:0]      bif_after;
   logic                     eq_a, eq_b;

   function automatic count_type close_field(count_type c, logic eq);
      count_type r;
      r = c;
      if (c.number == FIELD_MAX) begin
         r.flag = 1'b1;
      end else begin
         if (eq && c.found == '0) begin
            r.found = c.number + 1'b1;
         end
         r.number = c.number + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      plain        = entry.has_byte && !entry.is_sep;
      sep          = entry.has_byte && entry.is_sep;
      // an index at or past the needle length never matches, saturated ones included
      byte_differs = (entry.idx >= entry.len) || (rd_data != entry.byte_value);
      differs_after = differs_ff || (plain && byte_differs);
      bif_after = (plain && entry.idx < LEN_BITS'(NEEDLE_BYTES)) ?
                  entry.idx + 1'b1 : entry.idx;

      // a comma closes the running field first
      eq_a    = !differs_ff && !entry.too_long && entry.idx == entry.len;
      count_a = sep ? close_field(count_ff, eq_a) : count_ff;

      // end of list closes one more field, empty after a comma
      if (sep) begin
         eq_b = !entry.too_long && entry.len == '0;
      end else begin
         eq_b = !differs_after && !entry.too_long && bif_after == entry.len;
      end
      count_b = close_field(count_a, eq_b);

      result.position        = OUT_POS_BITS'(count_b.found);
      result.needle_overflow = entry.too_long;
      result.count_saturated = count_b.flag;

      differs_in = differs_ff;
      count_in   = count_ff;
      if (step) begin
         if (entry.clear || (entry.is_list && entry.last)) begin
            differs_in = 1'b0;
            count_in   = '0;
         end else if (entry.is_list) begin
            differs_in = sep ? 1'b0 : differs_after;
            count_in   = count_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         differs_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         differs_ff <= differs_in;
         count_ff   <= count_in;
      end
   end

endmodule

[src/find_in_comma_list.sv]
`timescale 1ns / 1ps
// Streaming search of a comma-separated list for a needle string. Send the
// needle one byte per item (command 0), then the list one byte per item
// (command 1). The item that closes the list yields one result: the 1-based
// number of the first field equal to the needle, or 0. The block takes one
// item per cycle while ready is high. The needle sits in a 64 x 8 RAM. Its
// registered read feeds the field compare, whose result is registered into the
// output register as the closing item leaves the s1 stage. Ready drops
// only while a result waits in the output register and the next result is due.
// No clearing pass follows reset.
module find_in_comma_list (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fic_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fic_pkg::rsp_type rsp_data
);
   import fic_pkg::*;

   logic [LEN_BITS-1:0] needle_len_ff, needle_len_in;
   logic                too_long_ff, too_long_in;
   logic                closed_ff, closed_in;
   logic [LEN_BITS-1:0] bif_ff, bif_in;
   logic                s1_valid_ff, s1_valid_in;
   stage_type           s1_ff, s1_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;

   logic                accept, is_needle, has_byte, is_sep, fresh, room;
   logic                s1_emits, s1_advance;
   logic [LEN_BITS-1:0] base_len;
   logic                base_long;
   logic                wr_en, rd_en;
   logic [7:0]          rd_data;
   rsp_type             result;

   assign s1_emits   = s1_valid_ff && s1_ff.is_list && s1_ff.last;
   assign s1_advance = s1_valid_ff && (!s1_emits || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;

   assign is_needle = req_data.command == CMD_NEEDLE;
   assign has_byte  = !req_data.no_byte;
   assign is_sep    = req_data.byte_value == SEPARATOR;
   // a needle item after a closed needle starts over
   assign fresh     = is_needle && closed_ff;
   assign base_len  = fresh ? '0 : needle_len_ff;
   assign base_long = fresh ? 1'b0 : too_long_ff;
   assign room      = base_len < LEN_BITS'(NEEDLE_BYTES);
   assign wr_en     = accept && is_needle && has_byte && room;
   assign rd_en     = accept && !is_needle;

   fic_ram #(
      .WIDTH (8),
      .DEPTH (NEEDLE_BYTES)
   ) u_needle_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (base_len[ADDR_BITS-1:0]),
      .wr_data (req_data.byte_value),
      .rd_en   (rd_en),
      .rd_addr (bif_ff[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      needle_len_in = needle_len_ff;
      too_long_in   = too_long_ff;
      closed_in     = closed_ff;
      bif_in        = bif_ff;
      if (accept) begin
         if (is_needle) begin
            needle_len_in = wr_en ? base_len + 1'b1 : base_len;
            too_long_in   = base_long || (has_byte && !room);
            closed_in     = req_data.end_of_string;
            if (fresh) begin
               bif_in = '0;
            end
         end else if (req_data.end_of_string || (has_byte && is_sep)) begin
            bif_in = '0;
         end else if (has_byte && bif_ff < LEN_BITS'(NEEDLE_BYTES)) begin
            bif_in = bif_ff + 1'b1;
         end
      end

      s1_in.clear      = fresh;
      s1_in.is_list    = !is_needle;
      s1_in.has_byte   = has_byte;
      s1_in.is_sep     = is_sep;
      s1_in.last       = req_data.end_of_string;
      s1_in.byte_value = req_data.byte_value;
      s1_in.idx        = bif_ff;
      s1_in.len        = needle_len_ff;
      s1_in.too_long   = too_long_ff;

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_advance && s1_emits) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   fic_field u_field (
      .clock   (clock),
      .reset   (reset),
      .step    (s1_advance),
      .entry   (s1_ff),
      .rd_data (rd_data),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_len_ff <= '0;
         too_long_ff   <= 1'b0;
         closed_ff     <= 1'b0;
         bif_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         needle_len_ff <= needle_len_in;
         too_long_ff   <= too_long_in;
         closed_ff     <= closed_in;
         bif_ff        <= bif_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // hold payloads while their stage waits
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_advance && s1_emits) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/fic_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fic_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input fic_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fic_pkg::rsp_type rsp_data
);
   import fic_pkg::*;

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
   `ASSERT_CLK(a_ready_free, clock, reset, !rsp_valid |-> req_ready)

endmodule

bind find_in_comma_list fic_checker u_fic_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
